// ----- rtl/crsc_pkg.sv -----
// shared types and constants for the conveyor ramp sorter control
`timescale 1ns / 1ps
`default_nettype none
package crsc_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned AddrW = 4;
  localparam int unsigned BusW  = 32;

  localparam logic [DataW-1:0] DutyMaxRst = 8'd255;
  localparam logic [DataW-1:0] RouteARst  = 8'd0;
  localparam logic [DataW-1:0] RouteBRst  = 8'd60;

  // command characters
  localparam logic [7:0] CmdStop  = 8'h45; // E
  localparam logic [7:0] CmdStart = 8'h49; // I
  localparam logic [7:0] CmdBrake = 8'h46; // F
  localparam logic [7:0] CmdRipe  = 8'h4D; // M
  localparam logic [7:0] CmdGreen = 8'h56; // V

  typedef enum logic [1:0] {
    REG_DUTY_MAX = 2'd0,
    REG_ROUTE_A  = 2'd1,
    REG_ROUTE_B  = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_CMD   = 2'd0,
    OP_TICK  = 2'd1,
    OP_ESTOP = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    MODE_WAIT  = 2'd0,
    MODE_ACCEL = 2'd1,
    MODE_OPER  = 2'd2,
    MODE_BRAKE = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    EV_NONE    = 4'd0,
    EV_SWSTOP  = 4'd1,
    EV_HWSTOP  = 4'd2,
    EV_START   = 4'd3,
    EV_BRAKE   = 4'd4,
    EV_RIPE    = 4'd5,
    EV_GREEN   = 4'd6,
    EV_FULL    = 4'd7,
    EV_STOPPED = 4'd8
  } event_t;

  typedef struct packed {
    logic [DataW-1:0] duty_max;
    logic [DataW-1:0] route_a_angle;
    logic [DataW-1:0] route_b_angle;
  } cfg_t;

endpackage
`default_nettype wire

// ----- rtl/crsc_cfg_regs.sv -----
// configuration register file behind the apb-style port
`timescale 1ns / 1ps
`default_nettype none
module crsc_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [crsc_pkg::AddrW-1:0]  paddr,
  input  wire logic [crsc_pkg::BusW-1:0]   pwdata,
  output logic      [crsc_pkg::BusW-1:0]   prdata,
  output logic                             pready,
  output crsc_pkg::cfg_t                   cfg
);

  crsc_pkg::cfg_t   cfg_r;
  crsc_pkg::reg_idx_t idx;
  logic             wr_en;

  assign idx    = crsc_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.duty_max      <= crsc_pkg::DutyMaxRst;
      cfg_r.route_a_angle <= crsc_pkg::RouteARst;
      cfg_r.route_b_angle <= crsc_pkg::RouteBRst;
    end else if (wr_en) begin
      unique case (idx)
        crsc_pkg::REG_DUTY_MAX: cfg_r.duty_max      <= pwdata[crsc_pkg::DataW-1:0];
        crsc_pkg::REG_ROUTE_A:  cfg_r.route_a_angle <= pwdata[crsc_pkg::DataW-1:0];
        crsc_pkg::REG_ROUTE_B:  cfg_r.route_b_angle <= pwdata[crsc_pkg::DataW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      crsc_pkg::REG_DUTY_MAX: prdata[crsc_pkg::DataW-1:0] = cfg_r.duty_max;
      crsc_pkg::REG_ROUTE_A:  prdata[crsc_pkg::DataW-1:0] = cfg_r.route_a_angle;
      crsc_pkg::REG_ROUTE_B:  prdata[crsc_pkg::DataW-1:0] = cfg_r.route_b_angle;
      default:                prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/crsc_seq.sv -----
// input register, mode/ramp/gate update and result register
`timescale 1ns / 1ps
`default_nettype none
module crsc_seq (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire crsc_pkg::cfg_t              cfg,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_op,
  input  wire logic [7:0]                  in_cmd_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [crsc_pkg::DataW-1:0]       out_motor_duty,
  output logic [crsc_pkg::DataW-1:0]       out_servo_angle,
  output logic [1:0]                       out_mode,
  output logic [3:0]                       out_event_res
);

  // input stage
  logic                       s1_valid_r;
  logic [1:0]                 s1_op_r;
  logic [7:0]                 s1_cmd_r;
  // block state
  crsc_pkg::mode_t            mode_r, mode_nxt;
  logic [crsc_pkg::DataW-1:0] duty_r, duty_nxt;
  logic                       route_b_r, route_b_nxt;
  crsc_pkg::event_t           ev_nxt;
  // result stage
  logic                       o_valid_r;
  logic [crsc_pkg::DataW-1:0] o_duty_r, o_angle_r;
  crsc_pkg::mode_t            o_mode_r;
  crsc_pkg::event_t           o_ev_r;

  logic s1_adv, in_take;

  assign s1_adv   = s1_valid_r && (!o_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    mode_nxt    = mode_r;
    duty_nxt    = duty_r;
    route_b_nxt = route_b_r;
    ev_nxt      = crsc_pkg::EV_NONE;
    case (crsc_pkg::op_t'(s1_op_r))
      crsc_pkg::OP_CMD: begin
        if (s1_cmd_r == crsc_pkg::CmdStop) begin
          mode_nxt    = crsc_pkg::MODE_WAIT;
          duty_nxt    = '0;
          route_b_nxt = 1'b0;
          ev_nxt      = crsc_pkg::EV_SWSTOP;
        end else if (mode_r == crsc_pkg::MODE_WAIT && s1_cmd_r == crsc_pkg::CmdStart) begin
          mode_nxt = crsc_pkg::MODE_ACCEL;
          ev_nxt   = crsc_pkg::EV_START;
        end else if (mode_r == crsc_pkg::MODE_OPER) begin
          if (s1_cmd_r == crsc_pkg::CmdBrake) begin
            mode_nxt = crsc_pkg::MODE_BRAKE;
            ev_nxt   = crsc_pkg::EV_BRAKE;
          end else if (s1_cmd_r == crsc_pkg::CmdRipe && !route_b_r) begin
            route_b_nxt = 1'b1;
            ev_nxt      = crsc_pkg::EV_RIPE;
          end else if (s1_cmd_r == crsc_pkg::CmdGreen && route_b_r) begin
            route_b_nxt = 1'b0;
            ev_nxt      = crsc_pkg::EV_GREEN;
          end
        end
      end
      crsc_pkg::OP_TICK: begin
        if (mode_r == crsc_pkg::MODE_ACCEL) begin
          if (duty_r < cfg.duty_max) begin
            duty_nxt = duty_r + 8'd1;
          end else begin
            // full speed reported one tick after reaching the limit
            mode_nxt = crsc_pkg::MODE_OPER;
            ev_nxt   = crsc_pkg::EV_FULL;
          end
        end else if (mode_r == crsc_pkg::MODE_BRAKE) begin
          if (duty_r != '0) begin
            duty_nxt = duty_r - 8'd1;
          end else begin
            mode_nxt = crsc_pkg::MODE_WAIT;
            ev_nxt   = crsc_pkg::EV_STOPPED;
          end
        end
      end
      crsc_pkg::OP_ESTOP: begin
        mode_nxt    = crsc_pkg::MODE_WAIT;
        duty_nxt    = '0;
        route_b_nxt = 1'b0;
        ev_nxt      = crsc_pkg::EV_HWSTOP;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
      mode_r     <= crsc_pkg::MODE_WAIT;
      duty_r     <= '0;
      route_b_r  <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        o_valid_r <= 1'b1;
        mode_r    <= mode_nxt;
        duty_r    <= duty_nxt;
        route_b_r <= route_b_nxt;
      end else if (!out_stall) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r  <= in_op;
      s1_cmd_r <= in_cmd_byte;
    end
    if (s1_adv) begin
      o_duty_r  <= duty_nxt;
      o_angle_r <= route_b_nxt ? cfg.route_b_angle : cfg.route_a_angle;
      o_mode_r  <= mode_nxt;
      o_ev_r    <= ev_nxt;
    end
  end

  assign out_valid       = o_valid_r;
  assign out_motor_duty  = o_duty_r;
  assign out_servo_angle = o_angle_r;
  assign out_mode        = o_mode_r;
  assign out_event_res   = o_ev_r;

endmodule
`default_nettype wire

// ----- rtl/conveyor_ramp_sorter_control.sv -----
// top level of the conveyor ramp sorter control
//
// channel   direction  beat contents
// in_       input      op, cmd_byte
// out_      output     motor_duty, servo_angle, mode, event_res
// apb       config     duty_max @0x0, route_a_angle @0x4, route_b_angle @0x8
//
// one beat in, one beat out; an item passes from in to out through the input register
// and then the result register, and one item is taken every cycle unless in_stall is high
// the mode, duty and route registers update as an item moves into the result register
// out_stall holds the result register; in_stall rises only while both stages are full
// synchronous active-low reset: mode waiting, duty zero, green route, registers to defaults
`timescale 1ns / 1ps
`default_nettype none
module conveyor_ramp_sorter_control (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_op,
  input  wire logic [7:0]                  in_cmd_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [7:0]                       out_motor_duty,
  output logic [7:0]                       out_servo_angle,
  output logic [1:0]                       out_mode,
  output logic [3:0]                       out_event_res,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [crsc_pkg::AddrW-1:0]  paddr,
  input  wire logic [crsc_pkg::BusW-1:0]   pwdata,
  output logic      [crsc_pkg::BusW-1:0]   prdata,
  output logic                             pready
);

  crsc_pkg::cfg_t cfg;

  crsc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  crsc_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_cmd_byte     (in_cmd_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_motor_duty  (out_motor_duty),
    .out_servo_angle (out_servo_angle),
    .out_mode        (out_mode),
    .out_event_res   (out_event_res)
  );

endmodule
`default_nettype wire

// ----- sim/tb_conveyor_ramp_sorter_control.sv -----
// testbench for the conveyor ramp sorter control: directed and random beats checked against a local model
`timescale 1ns / 1ps
module tb_conveyor_ramp_sorter_control;
  import crsc_pkg::*;

  localparam logic [1:0]  OpUnused     = 2'd3;
  localparam int unsigned StuckLimit   = 400;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned ItemsTarget  = 300;
  localparam int unsigned PhaseItems   = 60;
  localparam int unsigned PrintCap     = 50;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] cmd;
  } item_t;

  typedef struct packed {
    logic [7:0] duty;
    logic [7:0] angle;
    mode_t      mode;
    event_t     ev;
  } beat_t;

  logic             clk;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  wire              in_stall;
  logic [1:0]       in_op       = '0;
  logic [7:0]       in_cmd_byte = '0;
  wire              out_valid;
  logic             out_stall   = 1'b0;
  wire  [7:0]       out_motor_duty;
  wire  [7:0]       out_servo_angle;
  wire  [1:0]       out_mode;
  wire  [3:0]       out_event_res;
  logic             psel        = 1'b0;
  logic             penable     = 1'b0;
  logic             pwrite      = 1'b0;
  logic [AddrW-1:0] paddr       = '0;
  logic [BusW-1:0]  pwdata      = '0;
  wire  [BusW-1:0]  prdata;
  wire              pready;

  // local copy of the conveyor state and registers
  mode_t      model_mode = MODE_WAIT;
  logic [7:0] model_duty = '0;
  bit         model_ripe = 1'b0;
  logic [7:0] duty_max_q = DutyMaxRst;
  logic [7:0] angle_a_q  = RouteARst;
  logic [7:0] angle_b_q  = RouteBRst;

  item_t pending_items[$];
  beat_t expected_beats[$];
  item_t next_item;
  beat_t want;

  int unsigned total_queued   = 0;
  int unsigned total_accepted = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned send_wait      = 0;
  int unsigned send_quiet     = 0;
  int unsigned recv_wait      = 0;
  int unsigned recv_quiet     = 0;

  conveyor_ramp_sorter_control dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_cmd_byte     (in_cmd_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_motor_duty  (out_motor_duty),
    .out_servo_angle (out_servo_angle),
    .out_mode        (out_mode),
    .out_event_res   (out_event_res),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < PrintCap) $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // advance the conveyor by one beat and queue the result it should give
  task automatic conveyor_step(input logic [1:0] op, input logic [7:0] cmd);
    beat_t  b;
    event_t ev;
    ev = EV_NONE;
    case (op)
      OP_CMD: begin
        if (cmd == CmdStop) begin
          model_mode = MODE_WAIT;
          model_duty = '0;
          model_ripe = 1'b0;
          ev = EV_SWSTOP;
        end else if (model_mode == MODE_WAIT && cmd == CmdStart) begin
          model_mode = MODE_ACCEL;
          ev = EV_START;
        end else if (model_mode == MODE_OPER) begin
          if (cmd == CmdBrake) begin
            model_mode = MODE_BRAKE;
            ev = EV_BRAKE;
          end else if (cmd == CmdRipe && !model_ripe) begin
            model_ripe = 1'b1;
            ev = EV_RIPE;
          end else if (cmd == CmdGreen && model_ripe) begin
            model_ripe = 1'b0;
            ev = EV_GREEN;
          end
        end
      end
      OP_TICK: begin
        if (model_mode == MODE_ACCEL) begin
          if (model_duty < duty_max_q) begin
            model_duty = model_duty + 8'd1;
          end else begin
            model_mode = MODE_OPER;
            ev = EV_FULL;
          end
        end else if (model_mode == MODE_BRAKE) begin
          if (model_duty != 8'd0) begin
            model_duty = model_duty - 8'd1;
          end else begin
            model_mode = MODE_WAIT;
            ev = EV_STOPPED;
          end
        end
      end
      OP_ESTOP: begin
        model_mode = MODE_WAIT;
        model_duty = '0;
        model_ripe = 1'b0;
        ev = EV_HWSTOP;
      end
      default: begin
      end
    endcase
    b.duty  = model_duty;
    b.angle = model_ripe ? angle_b_q : angle_a_q;
    b.mode  = model_mode;
    b.ev    = ev;
    expected_beats.push_back(b);
  endtask

  task automatic push_item(input logic [1:0] op, input logic [7:0] cmd);
    item_t it;
    it.op  = op;
    it.cmd = cmd;
    pending_items.push_back(it);
    total_queued++;
  endtask

  function automatic logic [7:0] pick_command();
    case ($urandom_range(0, 4))
      0: return CmdStop;
      1: return CmdStart;
      2: return CmdBrake;
      3: return CmdRipe;
      default: return CmdGreen;
    endcase
  endfunction

  // a stray beat now and then: any op, any byte
  task automatic queue_noise(input int unsigned odds);
    if (odds != 0 && $urandom_range(1, odds) == 1)
      push_item(2'($urandom_range(0, 3)),
                $urandom_range(0, 1) ? 8'($urandom) : pick_command());
  endtask

  // start, ramp up to full speed, shuffle the gate, brake back down to stop
  task automatic queue_ramp_cycle(input int unsigned top, input int unsigned odds);
    int unsigned n;
    queue_noise(odds);
    push_item(OP_CMD, CmdStart);
    n = top + 1 + $urandom_range(0, 2);
    repeat (n) begin
      queue_noise(odds);
      push_item(OP_TICK, 8'($urandom));
    end
    repeat ($urandom_range(0, 5)) begin
      queue_noise(odds);
      push_item(OP_CMD, $urandom_range(0, 1) ? CmdRipe : CmdGreen);
    end
    push_item(OP_CMD, CmdBrake);
    n = top + 1 + $urandom_range(0, 2);
    repeat (n) begin
      queue_noise(odds);
      push_item(OP_TICK, 8'($urandom));
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] value);
    logic [23:0] junk;
    junk = 24'($urandom);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DUTY_MAX: duty_max_q = value;
      REG_ROUTE_A:  angle_a_q  = value;
      REG_ROUTE_B:  angle_b_q  = value;
      default: begin
      end
    endcase
  endtask

  task automatic check_reg(input reg_idx_t idx, input logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {{(BusW-8){1'b0}}, value})
      report_mismatch($sformatf("register %0d reads %0h, want %0h", idx, prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_regs();
    check_reg(REG_DUTY_MAX, duty_max_q);
    check_reg(REG_ROUTE_A, angle_a_q);
    check_reg(REG_ROUTE_B, angle_b_q);
  endtask

  // every queued beat taken and every result back, then let the pipeline empty
  task automatic wait_settled();
    do @(posedge clk);
    while (total_accepted != total_queued || expected_beats.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        conveyor_step(in_op, in_cmd_byte);
        total_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (send_wait > 0) begin
          in_valid <= 1'b0;
          send_wait--;
        end else if (pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          in_valid    <= 1'b1;
          in_op       <= next_item.op;
          in_cmd_byte <= next_item.cmd;
          if (send_quiet > 0) send_quiet--;
          else if ($urandom_range(0, 7) == 0) send_quiet = $urandom_range(8, 40);
          send_wait = (send_quiet > 0) ? 0 : $urandom_range(0, 14);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("result beat with no item outstanding");
        end else begin
          want = expected_beats.pop_front();
          if (out_motor_duty !== want.duty)
            report_mismatch($sformatf("motor_duty %0d, want %0d", out_motor_duty, want.duty));
          if (out_servo_angle !== want.angle)
            report_mismatch($sformatf("servo_angle %0d, want %0d", out_servo_angle, want.angle));
          if (out_mode !== want.mode)
            report_mismatch($sformatf("mode %0d, want %0d", out_mode, want.mode));
          if (out_event_res !== want.ev)
            report_mismatch($sformatf("event_res %0d, want %0d", out_event_res, want.ev));
        end
        if (recv_quiet > 0) recv_quiet--;
        else if ($urandom_range(0, 7) == 0) recv_quiet = $urandom_range(8, 40);
        recv_wait = (recv_quiet > 0) ? 0 : $urandom_range(0, 14);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_stall <= (recv_wait > 0);
    end
  end

  // watchdog on cycles where no beat and no register access moves
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= StuckLimit);
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned random_base;
    int unsigned phase_base;
    logic [7:0]  dmax;
    logic [7:0]  ang_a;
    logic [7:0]  ang_b;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    check_regs();

    // reset registers: noise while waiting, then a start cut short by a stop
    push_item(OP_TICK, 8'hFF);
    push_item(OP_CMD, CmdBrake);
    push_item(OpUnused, 8'hAA);
    push_item(OP_CMD, 8'h00);
    push_item(OP_CMD, CmdStart);
    push_item(OP_CMD, CmdStart);
    push_item(OP_TICK, 8'h55);
    push_item(OP_CMD, CmdStop);
    wait_settled();

    // short ramp, full speed, gate both ways, emergency while braking on ripe
    write_reg(REG_DUTY_MAX, 8'd3);
    check_regs();
    push_item(OP_CMD, CmdStart);
    repeat (4) push_item(OP_TICK, 8'h00);
    push_item(OP_CMD, CmdGreen);
    push_item(OP_CMD, CmdRipe);
    push_item(OP_CMD, CmdRipe);
    push_item(OP_CMD, CmdGreen);
    push_item(OP_CMD, CmdRipe);
    push_item(OP_CMD, CmdBrake);
    push_item(OP_TICK, 8'h00);
    push_item(OP_ESTOP, 8'hFF);
    wait_settled();

    // zero duty_max goes to full speed on the first tick; unmapped address ignored
    write_reg(REG_DUTY_MAX, 8'd0);
    write_reg(REG_NONE, 8'hFF);
    check_regs();
    push_item(OP_CMD, CmdStart);
    push_item(OP_TICK, 8'h00);
    push_item(OP_CMD, CmdBrake);
    push_item(OP_TICK, 8'h00);
    wait_settled();

    // duty_max dropped under the duty mid-ramp: full speed, duty kept
    write_reg(REG_DUTY_MAX, 8'd10);
    push_item(OP_CMD, CmdStart);
    repeat (3) push_item(OP_TICK, 8'h00);
    wait_settled();
    write_reg(REG_DUTY_MAX, 8'd1);
    push_item(OP_TICK, 8'h00);
    push_item(OP_CMD, CmdBrake);
    repeat (4) push_item(OP_TICK, 8'h00);
    wait_settled();

    random_base = total_queued;
    phase = 0;
    while (total_queued - random_base < ItemsTarget) begin
      case (phase)
        0: begin
          dmax = 8'd1;
          ang_a = 8'd0;
          ang_b = 8'd180;
        end
        1: begin
          dmax = 8'd2;
          ang_a = 8'd180;
          ang_b = 8'd0;
        end
        2: begin
          dmax = 8'd5;
          ang_a = 8'd255;
          ang_b = 8'd181;
        end
        default: begin
          dmax = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 12));
          ang_a = 8'($urandom_range(0, 180));
          ang_b = 8'($urandom_range(0, 180));
        end
      endcase
      write_reg(REG_DUTY_MAX, dmax);
      write_reg(REG_ROUTE_A, ang_a);
      write_reg(REG_ROUTE_B, ang_b);
      check_regs();
      phase_base = total_queued;
      while (total_queued - phase_base < PhaseItems) queue_ramp_cycle(dmax, 10);
      wait_settled();
      phase++;
    end

    // one clean ramp up to the top duty, ripe route, then a software stop
    write_reg(REG_DUTY_MAX, 8'd255);
    write_reg(REG_ROUTE_A, 8'($urandom_range(0, 180)));
    write_reg(REG_ROUTE_B, 8'd180);
    check_regs();
    push_item(OP_CMD, CmdStart);
    repeat (257) push_item(OP_TICK, 8'($urandom));
    push_item(OP_CMD, CmdRipe);
    push_item(OP_CMD, CmdStop);
    wait_settled();

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/crsc_pkg.sv
rtl/crsc_cfg_regs.sv
rtl/crsc_seq.sv
rtl/conveyor_ramp_sorter_control.sv
sim/tb_conveyor_ramp_sorter_control.sv
